/* hw/rtl/gas_sensor_heater_cycle_reader_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the heater cycle reader
// Shared property shorthands, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef GAS_SENSOR_HEATER_CYCLE_READER_MACROS_SVH
`define GAS_SENSOR_HEATER_CYCLE_READER_MACROS_SVH

// same-cycle implication
`define GSHC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gshc assertion failed");

// next-cycle implication
`define GSHC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gshc assertion failed");

`endif

/* hw/rtl/gshc_pkg.sv */
// ---------------------------------------------------------------------------
// gshc_pkg
// Types, codes and table functions of the heater cycle reader.
// ---------------------------------------------------------------------------
package gshc_pkg;

	// item kinds
	localparam logic [1:0] FUNC_TICK   = 2'd0;
	localparam logic [1:0] FUNC_SAMPLE = 2'd1;
	localparam logic [1:0] FUNC_CAL    = 2'd2;

	// result events
	localparam logic [2:0] EV_NONE    = 3'd0;
	localparam logic [2:0] EV_READING = 3'd1;
	localparam logic [2:0] EV_NOSAMP  = 3'd2;
	localparam logic [2:0] EV_OPEN    = 3'd3;
	localparam logic [2:0] EV_NOCAL   = 3'd4;

	// register indexes
	localparam logic [2:0] REG_HIGH_PHASE = 3'd0;
	localparam logic [2:0] REG_LOW_PHASE  = 3'd1;
	localparam logic [2:0] REG_WINDOW     = 3'd2;
	localparam logic [2:0] REG_LOW_DUTY   = 3'd3;
	localparam logic [2:0] REG_R0_START   = 3'd4;
	localparam logic [2:0] REG_CLEAN_RAT  = 3'd5;

	localparam int unsigned PE_MAX     = 131071;
	localparam int unsigned SUM_MAX    = 33554431;
	localparam int unsigned RS_MAX     = 8388607;
	localparam int unsigned R0_MAX     = 262143;
	localparam int unsigned RATIO_MAX  = 16777215;
	localparam int unsigned PPM_MAX    = 40000;
	localparam int unsigned FULL_DUTY  = 4095;
	localparam int unsigned LOG2_A_Q16 = 652207;
	localparam int unsigned B_MAG_Q16  = 99484;
	localparam int unsigned K_N        = 45500;
	localparam int unsigned K_S        = 11;
	localparam int unsigned K_NUM      = 300000;
	localparam int unsigned K_DEN      = 341;
	localparam int unsigned OPEN_MEAN  = 9;
	localparam int unsigned TAB_W      = 18;

	typedef enum logic [3:0] {
		ST_IDLE, ST_EVAL, ST_MUL_A, ST_MUL_B, ST_DIV_RS, ST_RS, ST_DIV_R0,
		ST_DIV_RT, ST_NORM, ST_LOG_A, ST_LOG_B, ST_SCALE, ST_EXP_A, ST_EXP_B,
		ST_EMIT
	} gshc_state_t;

	// fraction of log2(x/65536), x in [65536,131071], by repeated squaring
	function automatic logic [15:0] log2_frac(input longint unsigned x);
		longint unsigned y;
		logic [15:0]     r;
		y = x;
		r = '0;
		for (int k = 0; k < 16; k++) begin
			y = (y * y) >> 16;
			if (y >= 64'd131072) begin
				y = y >> 1;
				r[15-k] = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic logic [TAB_W-1:0] log_entry(input longint unsigned t, input bit last);
		if (last)
			return TAB_W'(65536);
		return TAB_W'(log2_frac(64'd65536 + t));
	endfunction

	function automatic logic [TAB_W-1:0] exp_entry(input longint unsigned t, input bit last);
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		lo = 65536;
		hi = 131071;
		if (last)
			return TAB_W'(131072);
		while (lo < hi) begin
			mid = lo + ((hi - lo + 1) >> 1);
			if (64'(log2_frac(mid)) <= t)
				lo = mid;
			else
				hi = mid - 1;
		end
		return TAB_W'(lo);
	endfunction

endpackage

/* hw/rtl/gshc_div.sv */
// ---------------------------------------------------------------------------
// gshc_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module gshc_div import gshc_pkg::*; #(
	parameter int DVD_W = 48,
	parameter int DVS_W = 36
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CW = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

/* hw/rtl/gas_sensor_heater_cycle_reader.sv */
// ---------------------------------------------------------------------------
// gas_sensor_heater_cycle_reader
// Heater cycle sequencer, window averager and CO estimate in tenths of ppm.
// ---------------------------------------------------------------------------
// Sequence: a tick, sample or calibration request is taken in idle, evaluated and then
//   loaded into the output register; a cycle end with a valid reading also runs up to
//   three serial divisions, a normalize loop, log2 and exp2 interpolation and a scale
//   step before the result is loaded; the divisions set the long case.
// Items are taken one at a time: the next only once the result is loaded into the output.
// Reset: arst_n clears counters and output valid, starts the full phase, loads defaults.
module gas_sensor_heater_cycle_reader import gshc_pkg::*; #(
	parameter int MAX_SAMPLES    = 8191,
	parameter int LOG_TABLE_SIZE = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	// slave side
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [15:0]  s_tdata,   // [11:0] adc_value, [15:12] zero
	input  logic [1:0]   s_tuser,   // [1:0] func
	// master side
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,   // [0] heater_full, [12:1] heater_duty, [13] led_on,
	                                // [29:14] ppm_tenths, [52:30] rs_ohms,
	                                // [70:53] r0_ohms, [71] cal_done, [103:72] cycle_total
	output logic [2:0]   m_tuser,   // [2:0] event_res
	// configuration
	input  logic         cfg_we,
	input  logic [2:0]   cfg_addr,
	input  logic [17:0]  cfg_wdata
);

	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int DIFF_W = CNT_W + 16;
	localparam int NUM_W  = DIFF_W + 19;
	localparam int DEN_W  = 34;
	localparam int DVD_W  = (NUM_W + 2 > 40) ? NUM_W + 2 : 40;
	localparam int DVS_W  = 36;
	localparam int TAB_AW = $clog2(LOG_TABLE_SIZE + 1);
	localparam int POS_W  = 16 + TAB_AW;

	// configuration registers
	logic [16:0] high_phase_q, low_phase_q, window_q;
	logic [11:0] low_duty_q, clean_ratio_q;

	// block state
	gshc_state_t state_q, state_d;
	logic             full_q;
	logic [16:0]      pe_q;
	logic [24:0]      sum_q;
	logic [CNT_W-1:0] total_q;
	logic [31:0]      cycles_q;
	logic             cal_pend_q;
	logic [17:0]      ref_q;

	// item and working registers
	logic [1:0]       func_q;
	logic [11:0]      adc_q;
	logic [CNT_W-1:0] n_q;
	logic [24:0]      s_q;
	logic [DIFF_W-1:0] diff_q;
	logic [22:0]      rs_q;
	logic [23:0]      norm_q;
	logic [4:0]       shcnt_q;
	logic [TAB_W-1:0] lerp_a_q;
	logic [33:0]      lerp_p_q;
	logic signed [39:0] scl_q;
	logic [20:0]      e_q;

	// result
	logic [2:0]  res_ev_q;
	logic [15:0] res_ppm_q;
	logic [22:0] res_rs_q;
	logic        res_cal_q;

	logic         m_tvalid_q;
	logic [103:0] m_tdata_q;
	logic [2:0]   m_tuser_q;

	// ---------------------------------------------------------------------
	// Item evaluation terms
	// ---------------------------------------------------------------------
	logic [16:0] pe_inc;
	logic [16:0] thr;
	logic        cyc_end;
	logic        in_window;
	logic [25:0] sum_add;
	logic        reading;

	assign pe_inc    = (pe_q < 17'(PE_MAX)) ? pe_q + 17'd1 : pe_q;
	assign thr       = (window_q < low_phase_q) ? low_phase_q - window_q : '0;
	assign cyc_end   = (func_q == FUNC_TICK) && !full_q && (pe_inc >= low_phase_q);
	assign in_window = !full_q && (pe_q >= thr) && (32'(total_q) < 32'(MAX_SAMPLES));
	assign sum_add   = {1'b0, sum_q} + 26'(adc_q);
	assign reading   = (total_q != '0) && (32'(sum_q) >= 32'(OPEN_MEAN) * 32'(total_q));

	// ---------------------------------------------------------------------
	// Divider operands
	// ---------------------------------------------------------------------
	logic             div_start;
	logic             div_done;
	logic [DVD_W-1:0] div_dvd;
	logic [DVS_W-1:0] div_dvs;
	logic [DVD_W-1:0] div_quot;
	logic [NUM_W-1:0] num_w;
	logic [DEN_W-1:0] den_w;
	logic [11:0]      c_w;

	assign num_w = NUM_W'(K_NUM) * NUM_W'(diff_q);
	assign den_w = DEN_W'(K_DEN) * DEN_W'(s_q);
	assign c_w   = (clean_ratio_q == '0) ? 12'd1 : clean_ratio_q;

	always_comb begin
		div_dvd = DVD_W'({rs_q, 16'd0});
		div_dvs = DVS_W'(ref_q);
		if (state_q == ST_MUL_B) begin
			div_dvd = DVD_W'({num_w, 1'b0}) + DVD_W'(den_w);
			div_dvs = DVS_W'({den_w, 1'b0});
		end else if (cal_pend_q) begin
			div_dvd = DVD_W'({rs_q, 5'd0}) + DVD_W'(c_w);
			div_dvs = DVS_W'({c_w, 1'b0});
		end
	end

	gshc_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quot)
	);

	// ---------------------------------------------------------------------
	// log2 / exp2 tables with shared interpolation
	// ---------------------------------------------------------------------
	logic [TAB_W-1:0] log_tab [0:LOG_TABLE_SIZE];
	logic [TAB_W-1:0] exp_tab [0:LOG_TABLE_SIZE];

	for (genvar g = 0; g <= LOG_TABLE_SIZE; g++) begin : g_tab
		localparam longint unsigned T = (longint'(g) * 65536) / LOG_TABLE_SIZE;
		localparam logic [TAB_W-1:0] LV = log_entry(T, g == LOG_TABLE_SIZE);
		localparam logic [TAB_W-1:0] EV = exp_entry(T, g == LOG_TABLE_SIZE);
		assign log_tab[g] = LV;
		assign exp_tab[g] = EV;
	end

	logic [15:0]       lerp_frac;
	logic [POS_W-1:0]  lerp_pos;
	logic [TAB_AW-1:0] lerp_idx;
	logic [TAB_W-1:0]  lerp_a, lerp_b;
	logic [TAB_W-1:0]  lerp_out;

	assign lerp_frac = (state_q == ST_LOG_A) ? norm_q[22:7] : e_q[15:0];
	assign lerp_pos  = POS_W'(lerp_frac) * POS_W'(LOG_TABLE_SIZE);

	always_comb begin
		lerp_idx = lerp_pos[POS_W-1:16];
		if (32'(lerp_idx) >= 32'(LOG_TABLE_SIZE))
			lerp_idx = TAB_AW'(LOG_TABLE_SIZE - 1);
		if (state_q == ST_LOG_A) begin
			lerp_a = log_tab[lerp_idx];
			lerp_b = log_tab[lerp_idx + 1'b1];
		end else begin
			lerp_a = exp_tab[lerp_idx];
			lerp_b = exp_tab[lerp_idx + 1'b1];
		end
		if (lerp_b < lerp_a)
			lerp_b = lerp_a;
	end

	assign lerp_out = lerp_a_q + TAB_W'(lerp_p_q[33:16]);

	// log2 of ratio in Q16, then scaled by the exponent magnitude
	logic signed [5:0]  int_part;
	logic signed [21:0] lq;
	assign int_part = 6'sd7 - $signed({1'b0, shcnt_q});
	assign lq       = $signed({int_part, 16'd0}) + $signed(22'(lerp_out));

	// truncate toward zero, then E = log2(A) - B*L
	logic signed [39:0] scl_trunc;
	logic signed [39:0] e_full;
	assign scl_trunc = (scl_q + (scl_q[39] ? 40'sd65535 : 40'sd0)) >>> 16;
	assign e_full    = 40'(LOG2_A_Q16) - scl_trunc;

	logic [33:0] exp_v;
	logic [16:0] exp_r;
	assign exp_v = 34'(lerp_out) << e_q[20:16];
	assign exp_r = 17'((exp_v + 34'd65536) >> 17);

	// ---------------------------------------------------------------------
	// Sequencer: next state
	// ---------------------------------------------------------------------
	logic out_load;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (s_tvalid) state_d = ST_EVAL;
			ST_EVAL:   state_d = (cyc_end && reading) ? ST_MUL_A : ST_EMIT;
			ST_MUL_A:  state_d = ST_MUL_B;
			ST_MUL_B:  state_d = ST_DIV_RS;
			ST_DIV_RS: if (div_done) state_d = ST_RS;
			ST_RS: begin
				if (cal_pend_q)
					state_d = ST_DIV_R0;
				else if (ref_q == '0)
					state_d = ST_EMIT;
				else
					state_d = ST_DIV_RT;
			end
			ST_DIV_R0: if (div_done) state_d = ST_RS;
			ST_DIV_RT: if (div_done) state_d = ST_NORM;
			ST_NORM:   if (norm_q[23]) state_d = ST_LOG_A;
			ST_LOG_A:  state_d = ST_LOG_B;
			ST_LOG_B:  state_d = ST_SCALE;
			ST_SCALE: begin
				if (e_full >= 40'sd1048576 || e_full < -40'sd65536)
					state_d = ST_EMIT;
				else
					state_d = ST_EXP_A;
			end
			ST_EXP_A:  state_d = ST_EXP_B;
			ST_EXP_B:  state_d = ST_EMIT;
			ST_EMIT:   if (out_load) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Sequencer: strobes
	always_comb begin
		s_tready  = (state_q == ST_IDLE);
		out_load  = (state_q == ST_EMIT) && (!m_tvalid_q || m_tready);
		div_start = (state_q == ST_MUL_B) ||
		            ((state_q == ST_RS) && (cal_pend_q || (ref_q != '0)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// ---------------------------------------------------------------------
	// Configuration and block state
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_phase_q  <= 17'd60000;
			low_phase_q   <= 17'd90000;
			window_q      <= 17'd5000;
			low_duty_q    <= 12'd321;
			clean_ratio_q <= 12'd440;
			full_q        <= 1'b1;
			pe_q          <= '0;
			sum_q         <= '0;
			total_q       <= '0;
			cycles_q      <= '0;
			cal_pend_q    <= 1'b0;
			ref_q         <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_HIGH_PHASE: high_phase_q  <= cfg_wdata[16:0];
					REG_LOW_PHASE:  low_phase_q   <= cfg_wdata[16:0];
					REG_WINDOW:     window_q      <= cfg_wdata[16:0];
					REG_LOW_DUTY:   low_duty_q    <= cfg_wdata[11:0];
					REG_R0_START:   ref_q         <= cfg_wdata;
					REG_CLEAN_RAT:  clean_ratio_q <= cfg_wdata[11:0];
					default: ;
				endcase
			end
			if (state_q == ST_EVAL) begin
				case (func_q)
					FUNC_TICK: begin
						if (full_q ? (pe_inc >= high_phase_q) : cyc_end) begin
							// phase change: restart the window
							full_q  <= !full_q;
							pe_q    <= '0;
							sum_q   <= '0;
							total_q <= '0;
							if (!full_q)
								cycles_q <= cycles_q + 32'd1;
						end else begin
							pe_q <= pe_inc;
						end
					end
					FUNC_SAMPLE: begin
						if (in_window) begin
							total_q <= total_q + 1'b1;
							sum_q   <= sum_add[25] ? 25'(SUM_MAX) : sum_add[24:0];
						end
					end
					FUNC_CAL: cal_pend_q <= 1'b1;
					default: ;
				endcase
			end
			// store the new reference
			if (state_q == ST_DIV_R0 && div_done) begin
				cal_pend_q <= 1'b0;
				if (div_quot > DVD_W'(R0_MAX))
					ref_q <= 18'(R0_MAX);
				else if (div_quot == '0)
					ref_q <= 18'd1;
				else
					ref_q <= div_quot[17:0];
			end
		end
	end

	// ---------------------------------------------------------------------
	// Working registers and result
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				func_q <= s_tuser;
				adc_q  <= s_tdata[11:0];
			end
			ST_EVAL: begin
				n_q       <= total_q;
				s_q       <= sum_q;
				res_ev_q  <= EV_NONE;
				res_ppm_q <= '0;
				res_rs_q  <= '0;
				res_cal_q <= 1'b0;
				if (cyc_end)
					res_ev_q <= (total_q == '0) ? EV_NOSAMP :
					            (reading ? EV_NONE : EV_OPEN);
			end
			ST_MUL_A:
				diff_q <= DIFF_W'(K_N) * DIFF_W'(n_q) - DIFF_W'(K_S) * DIFF_W'(s_q);
			ST_DIV_RS:
				if (div_done)
					rs_q <= (div_quot > DVD_W'(RS_MAX)) ? 23'(RS_MAX) : div_quot[22:0];
			ST_RS:
				if (!cal_pend_q) begin
					res_rs_q <= rs_q;
					res_ev_q <= (ref_q == '0) ? EV_NOCAL : EV_READING;
				end
			ST_DIV_R0:
				if (div_done)
					res_cal_q <= 1'b1;
			ST_DIV_RT:
				if (div_done) begin
					shcnt_q <= '0;
					if (div_quot > DVD_W'(RATIO_MAX))
						norm_q <= 24'(RATIO_MAX);
					else if (div_quot == '0)
						norm_q <= 24'd1;
					else
						norm_q <= div_quot[23:0];
				end
			ST_NORM:
				// find the leading one, one place per cycle
				if (!norm_q[23]) begin
					norm_q  <= {norm_q[22:0], 1'b0};
					shcnt_q <= shcnt_q + 5'd1;
				end
			ST_LOG_A, ST_EXP_A: begin
				lerp_a_q <= lerp_a;
				lerp_p_q <= 34'(lerp_b - lerp_a) * 34'(lerp_pos[15:0]);
			end
			ST_LOG_B:
				scl_q <= $signed(40'(B_MAG_Q16)) * 40'(lq);
			ST_SCALE: begin
				e_q <= 21'(e_full + 40'sd65536);
				if (e_full >= 40'sd1048576)
					res_ppm_q <= 16'(PPM_MAX);
				else if (e_full < -40'sd65536)
					res_ppm_q <= '0;
			end
			ST_EXP_B:
				res_ppm_q <= (exp_r > 17'(PPM_MAX)) ? 16'(PPM_MAX) : exp_r[15:0];
			default: ;
		endcase
	end

	// ---------------------------------------------------------------------
	// Output register: hold until the transaction completes
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (out_load)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {cycles_q, res_cal_q, ref_q, res_rs_q, res_ppm_q, full_q,
			              (full_q ? 12'(FULL_DUTY) : low_duty_q), full_q};
			m_tuser_q <= res_ev_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

/* hw/rtl/gshc_checker.sv */
// ---------------------------------------------------------------------------
// gshc_checker
// Port-level checks on the result stream of the heater cycle reader.
// ---------------------------------------------------------------------------
`include "gas_sensor_heater_cycle_reader_macros.svh"

module gshc_checker import gshc_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [103:0] m_tdata,
	input logic [2:0]   m_tuser
);

	// stalled result holds
	`GSHC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	// event codes stop at not calibrated
	`GSHC_ASSERT_IMPL(a_event_range, m_tvalid, m_tuser <= EV_NOCAL)
	// concentration only with a reading, and clamped
	`GSHC_ASSERT_IMPL(a_ppm_event, m_tvalid && m_tuser != EV_READING, m_tdata[29:14] == 16'd0)
	`GSHC_ASSERT_IMPL(a_ppm_clamp, m_tvalid, m_tdata[29:14] <= 16'd40000)
	// full phase drives full duty and lights the indicator
	`GSHC_ASSERT_IMPL(a_heater, m_tvalid && m_tdata[0], m_tdata[13] && m_tdata[12:1] == 12'hFFF)

endmodule

bind gas_sensor_heater_cycle_reader gshc_checker u_gshc_checker (.*);
